// File: hdl/cdt_pkg.sv
// Package for the countdown timer block: item layout, access codes and timer constants.
// No dependencies; imported by every module of the block.
`default_nettype none
package cdt_pkg;

	typedef logic [2:0] op_t;

	localparam op_t OP_TIMER_READ  = 3'd0;
	localparam op_t OP_TIMER_WRITE = 3'd1;
	localparam op_t OP_REQ_READ    = 3'd2;
	localparam op_t OP_ACK         = 3'd3;
	localparam op_t OP_EN_READ     = 3'd4;
	localparam op_t OP_EN_WRITE    = 3'd5;
	localparam op_t OP_RAISE       = 3'd6;
	localparam op_t OP_TICK        = 3'd7;

	localparam logic [31:0] RELOAD_VALUE    = 32'h000F_FFFF;
	localparam logic [31:0] TICKS_PER_US    = 32'd25;
	localparam int          TIMER_LINE_BASE = 2;

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  index;
		op_t         op;
	} item_t;

endpackage
`default_nettype wire

// File: hdl/cdt_timers.sv
// Bank of one-shot countdown timers: load, read back and tick update.
// Depends on cdt_pkg; reports expiring timers to the interrupt latch.
`default_nettype none
module cdt_timers
	import cdt_pkg::*;
#(
	parameter int NUM_TIMERS = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire item_t                 item,
	output logic [31:0]                read_data,
	output logic [NUM_TIMERS-1:0]      expired
);

	logic [31:0]           count_q [NUM_TIMERS];
	logic [NUM_TIMERS-1:0] running_q;
	logic [31:0]           ticks;
	logic                  is_tick;

	assign ticks   = 32'(item.data * TICKS_PER_US);
	assign is_tick = (item.op == OP_TICK);

	always_comb begin
		read_data = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			expired[i] = advance && is_tick && running_q[i] && (count_q[i] <= ticks);
			if (item.op == OP_TIMER_READ && item.index == 3'(i))
				read_data = count_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			for (int i = 0; i < NUM_TIMERS; i++)
				count_q[i] <= '0;
		end else if (advance) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (item.op == OP_TIMER_WRITE && item.index == 3'(i)) begin
					count_q[i]   <= item.data;
					running_q[i] <= 1'b1;
				end else if (expired[i]) begin
					count_q[i]   <= RELOAD_VALUE;
					running_q[i] <= 1'b0;
				end else if (is_tick && running_q[i]) begin
					count_q[i] <= count_q[i] - ticks;
				end
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/cdt_irq.sv
// Interrupt request and enable latch: acknowledge, raise, enable and timer lines.
// Depends on cdt_pkg; takes expiry flags from cdt_timers.
`default_nettype none
module cdt_irq
	import cdt_pkg::*;
#(
	parameter int NUM_TIMERS = 4,
	parameter int SOUND_BIT  = 10
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire item_t                 item,
	input  wire logic [NUM_TIMERS-1:0] expired,
	output logic [31:0]                read_data
);

	logic [31:0] pending_q;
	logic [31:0] enabled_q;
	logic [31:0] tick_lines;

	always_comb begin
		tick_lines = '0;
		for (int i = 0; i < NUM_TIMERS; i++)
			tick_lines[i + TIMER_LINE_BASE] = expired[i];
	end

	always_comb begin
		case (item.op)
			OP_REQ_READ: read_data = pending_q;
			OP_EN_READ:  read_data = enabled_q;
			default:     read_data = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			enabled_q <= '0;
		end else if (advance) begin
			unique case (item.op)
				OP_ACK: pending_q <= pending_q & item.data;
				OP_EN_WRITE: begin
					enabled_q <= item.data;
					if (item.data[SOUND_BIT])
						pending_q[SOUND_BIT] <= 1'b1;
				end
				OP_RAISE: pending_q <= pending_q | item.data;
				OP_TICK:  pending_q <= pending_q | (tick_lines & enabled_q);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: hdl/countdown_timers_with_irq_latch.sv
// Top level of the countdown timer block: input register, timer bank, interrupt latch
// and result register. Depends on cdt_pkg, cdt_timers and cdt_irq.
//
// Each item is one register access or a tick. The block takes one item per cycle
// while its output is not stalled, and returns exactly one item per input. An item waits
// in the input register, is decoded and applied to the timers and the latch by
// combinational logic (the 32-bit tick product, compare and subtract set the path), and
// its read value lands in the result register, which holds while the output stalls.
`default_nettype none
module countdown_timers_with_irq_latch
	import cdt_pkg::*;
#(
	parameter int NUM_TIMERS = 4,
	parameter int SOUND_BIT  = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // op[2:0], index[5:3], data[37:6], zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata   // read_data[31:0]
);

	item_t       item_s1;
	logic        valid_s1;
	logic        advance;
	logic [31:0] read_data_q;
	logic        out_valid_q;
	logic [31:0] timer_rd;
	logic [31:0] irq_rd;
	logic [NUM_TIMERS-1:0] expired;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = read_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			item_s1 <= item_t'(s_axis_tdata[37:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			read_data_q <= timer_rd | irq_rd;
	end

	cdt_timers #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_timers (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.read_data (timer_rd),
		.expired   (expired)
	);

	cdt_irq #(
		.NUM_TIMERS(NUM_TIMERS),
		.SOUND_BIT (SOUND_BIT)
	) u_irq (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.item      (item_s1),
		.expired   (expired),
		.read_data (irq_rd)
	);

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for countdown_timers_with_irq_latch: timer loads, reads, ticks
// and interrupt latch accesses, checked against a built-in predictor of timers and latch.
// Depends on cdt_pkg and the block's RTL only.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cdt_pkg::*;

	localparam int TIMER_COUNT = 4;
	localparam int SOUND_LINE  = 10;
	localparam int RANDOM_ITEMS = 1300;
	localparam int TAIL_ITEMS  = 150;
	localparam int HOLD_LENGTH = 80;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;  // op[2:0], index[5:3], data[37:6], zero
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // read_data[31:0]

	countdown_timers_with_irq_latch #(
		.NUM_TIMERS(TIMER_COUNT),
		.SOUND_BIT(SOUND_LINE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	item_t       access_queue[$];
	logic [31:0] read_values_due[$];

	logic [31:0] timer_count[TIMER_COUNT];
	logic        timer_live[TIMER_COUNT];
	logic [31:0] req_latch;
	logic [31:0] en_latch;

	logic [31:0] predicted_read;
	int          send_gap;
	int          recv_gap;
	int          hold_cycles;
	logic        hold_done;
	logic        long_hold;
	logic        tail_phase;
	int          results_seen;
	int          fault_count;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	task automatic apply_access(input item_t acc, output logic [31:0] rd);
		logic [31:0] ticks;
		logic [31:0] line;
		logic [31:0] sound;
		begin
			rd = '0;
			sound = 32'd1 << SOUND_LINE;
			case (acc.op)
				OP_TIMER_READ: begin
					if (acc.index < TIMER_COUNT)
						rd = timer_count[acc.index];
				end
				OP_TIMER_WRITE: begin
					if (acc.index < TIMER_COUNT) begin
						timer_count[acc.index] = acc.data;
						timer_live[acc.index] = 1'b1;
					end
				end
				OP_REQ_READ: rd = req_latch;
				OP_ACK: req_latch = req_latch & acc.data;
				OP_EN_READ: rd = en_latch;
				OP_EN_WRITE: begin
					en_latch = acc.data;
					if (en_latch & sound)
						req_latch = req_latch | sound;
				end
				OP_RAISE: req_latch = req_latch | acc.data;
				default: begin
					ticks = acc.data * TICKS_PER_US;
					for (int i = 0; i < TIMER_COUNT; i++) begin
						if (timer_live[i]) begin
							if (timer_count[i] <= ticks) begin
								line = 32'd1 << (i + TIMER_LINE_BASE);
								timer_count[i] = RELOAD_VALUE;
								timer_live[i] = 1'b0;
								if (en_latch & line)
									req_latch = req_latch | line;
							end else begin
								timer_count[i] = timer_count[i] - ticks;
							end
						end
					end
				end
			endcase
		end
	endtask

	function automatic item_t make_access(op_t op, logic [2:0] idx, logic [31:0] data);
		item_t acc;
		acc.op = op;
		acc.index = idx;
		acc.data = data;
		return acc;
	endfunction

	function automatic item_t random_access();
		item_t acc;
		int pick;
		acc.op = op_t'($urandom_range(0, 7));
		acc.index = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
		acc.data = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 30)
			acc.op = OP_TICK;
		else if (pick < 55)
			acc.op = OP_TIMER_WRITE;
		case (acc.op)
			OP_TIMER_WRITE: begin
				if ($urandom_range(0, 9) < 6)
					acc.data = $urandom_range(0, 5000);
				else if ($urandom_range(0, 3) == 0)
					acc.data = '0;
			end
			OP_TICK: begin
				if ($urandom_range(0, 9) < 7)
					acc.data = $urandom_range(0, 100);
				else if ($urandom_range(0, 2) == 0)
					acc.data = '0;
			end
			OP_EN_WRITE: begin
				if ($urandom_range(0, 9) < 7)
					acc.data = acc.data | 32'h0000_043C;
			end
			OP_ACK: begin
				if ($urandom_range(0, 1) == 0)
					acc.data = ~(32'd1 << $urandom_range(0, 31));
			end
			OP_RAISE: begin
				if ($urandom_range(0, 1) == 0)
					acc.data = acc.data & $urandom() & $urandom();
			end
			default: ;
		endcase
		return acc;
	endfunction

	// sender: hold while stalled, predict on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			tail_phase <= 1'b0;
			send_gap = 0;
			for (int i = 0; i < TIMER_COUNT; i++) begin
				timer_count[i] = '0;
				timer_live[i] = 1'b0;
			end
			req_latch = '0;
			en_latch = '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				apply_access(access_queue.pop_front(), predicted_read);
				read_values_due.push_back(predicted_read);
			end
			tail_phase <= (access_queue.size() < TAIL_ITEMS);
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (access_queue.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (access_queue.size() >= TAIL_ITEMS && (access_queue.size() / 100) % 3 != 0
					&& $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 10);
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {2'b00, access_queue[0]};
			end
		end
	end

	// long receiver hold-off so the block fills and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_done <= 1'b0;
			hold_cycles = 0;
		end else if (long_hold) begin
			hold_cycles++;
			if (hold_cycles >= HOLD_LENGTH)
				long_hold <= 1'b0;
		end else if (!hold_done && results_seen >= 400) begin
			long_hold <= 1'b1;
			hold_done <= 1'b1;
		end
	end

	task automatic note_fault(input string what, input logic [31:0] want, input logic [31:0] got);
		begin
			if (fault_count < 10)
				$display("%0t: %s: expected %08h, got %08h", $realtime, what, want, got);
			fault_count++;
		end
	endtask

	// receiver: check each result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			results_seen <= 0;
			recv_gap = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				if (read_values_due.size() == 0)
					note_fault("unexpected result", 32'h0, m_axis_tdata);
				else if (m_axis_tdata !== read_values_due[0])
					note_fault("read_data mismatch", read_values_due.pop_front(), m_axis_tdata);
				else
					void'(read_values_due.pop_front());
			end
			if (long_hold) begin
				m_axis_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_axis_tready <= 1'b0;
			end else if (!tail_phase && (results_seen / 100) % 3 != 1 && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 10);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		fault_count = 0;
		arst_n = 1'b0;

		// reset values, out-of-range read
		access_queue.push_back(make_access(OP_TIMER_READ, 3'd0, 32'h0));
		access_queue.push_back(make_access(OP_TIMER_READ, 3'd7, 32'h0));
		// enable everything: sound line raised at once
		access_queue.push_back(make_access(OP_EN_WRITE, 3'd0, 32'hFFFF_FFFF));
		access_queue.push_back(make_access(OP_REQ_READ, 3'd0, 32'h0));
		access_queue.push_back(make_access(OP_ACK, 3'd0, 32'h0));
		access_queue.push_back(make_access(OP_TIMER_WRITE, 3'd0, 32'h0));
		access_queue.push_back(make_access(OP_TIMER_WRITE, 3'd1, 32'd100));
		access_queue.push_back(make_access(OP_TIMER_WRITE, 3'd2, 32'hFFFF_FFFF));
		access_queue.push_back(make_access(OP_TIMER_WRITE, 3'd3, 32'd50));
		access_queue.push_back(make_access(OP_TIMER_WRITE, 3'd5, 32'd123));
		access_queue.push_back(make_access(OP_TIMER_READ, 3'd5, 32'h0));
		// zero-length tick expires the timer holding zero
		access_queue.push_back(make_access(OP_TICK, 3'd0, 32'd0));
		access_queue.push_back(make_access(OP_TICK, 3'd0, 32'd4));
		access_queue.push_back(make_access(OP_TIMER_READ, 3'd1, 32'h0));
		access_queue.push_back(make_access(OP_TIMER_READ, 3'd2, 32'h0));
		// product wraps
		access_queue.push_back(make_access(OP_TICK, 3'd0, 32'hFFFF_FFFF));
		access_queue.push_back(make_access(OP_REQ_READ, 3'd0, 32'h0));
		// disabled lines: reload and stop without a request
		access_queue.push_back(make_access(OP_EN_WRITE, 3'd0, 32'h0));
		access_queue.push_back(make_access(OP_ACK, 3'd0, 32'h0));
		access_queue.push_back(make_access(OP_TIMER_WRITE, 3'd0, 32'd5));
		access_queue.push_back(make_access(OP_TICK, 3'd0, 32'd1));
		access_queue.push_back(make_access(OP_RAISE, 3'd0, 32'h8000_0001));
		access_queue.push_back(make_access(OP_REQ_READ, 3'd0, 32'h0));
		access_queue.push_back(make_access(OP_EN_READ, 3'd0, 32'h0));
		access_queue.push_back(make_access(OP_TIMER_READ, 3'd0, 32'h0));
		for (int n = 0; n < RANDOM_ITEMS; n++)
			access_queue.push_back(random_access());

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (access_queue.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (read_values_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
hdl/cdt_pkg.sv
hdl/cdt_timers.sv
hdl/cdt_irq.sv
hdl/countdown_timers_with_irq_latch.sv
tb/tb.sv
